### src/garp_pkg.sv
// shared types and constants for the gizmo axis ray pick block
`timescale 1ns / 1ps
`default_nettype none
package garp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DW = 32;
   localparam int TOL_W = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

   localparam int MUL_AW = 38;
   localparam int MUL_BW = 32;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   localparam int ROOT_STEPS = 32;
   localparam int ROOT_RW = 36;

   localparam logic [1:0] AXIS_NONE = 2'd0;

   typedef struct packed {
      logic signed [DW-1:0] ray_origin_x;
      logic signed [DW-1:0] ray_origin_y;
      logic signed [DW-1:0] ray_origin_z;
      logic signed [DW-1:0] ray_dir_x;
      logic signed [DW-1:0] ray_dir_y;
      logic signed [DW-1:0] ray_dir_z;
      logic signed [DW-1:0] object_x;
      logic signed [DW-1:0] object_y;
      logic signed [DW-1:0] object_z;
      logic                 axis_locked;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] picked_axis;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage
`default_nettype wire

### src/garp_mul.sv
// shared registered signed multiplier
`timescale 1ns / 1ps
`default_nettype none
module garp_mul import garp_pkg::*; (
   input  logic                     clock,
   input  logic signed [MUL_AW-1:0] mul_a,
   input  logic signed [MUL_BW-1:0] mul_b,
   output logic signed [MUL_PW-1:0] prod
);

   logic signed [MUL_PW-1:0] prod_ff;
   logic signed [MUL_PW-1:0] prod_in;

   assign prod_in = MUL_PW'(mul_a) * MUL_PW'(mul_b);
   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

### src/garp_root_div.sv
// iterative square root and divider, one bit or digit per cycle
`timescale 1ns / 1ps
`default_nettype none
module garp_root_div import garp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  unit_cmd_type            cmd,
   input  logic [63:0]             radicand,
   input  logic [DW+FRAC_BITS:0]   dividend,
   input  logic [DW-1:0]           divisor,
   output unit_stat_type           stat,
   output logic [DW-1:0]           result
);

   localparam int QW = FRAC_BITS + 1;
   localparam int CW = $clog2(ROOT_STEPS + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               div_ff, div_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [ROOT_RW-1:0] rem_ff, rem_in;
   logic [63:0]        src_ff, src_in;
   logic [DW-1:0]      res_ff, res_in;
   logic [DW-1:0]      dvs_ff, dvs_in;

   logic [ROOT_RW-1:0] t_root, trial, t_div, dvs_ext;

   assign t_root  = {rem_ff[ROOT_RW-3:0], src_ff[63:62]};
   assign trial   = ROOT_RW'({res_ff, 2'b01});
   assign t_div   = {rem_ff[ROOT_RW-2:0], src_ff[63]};
   assign dvs_ext = ROOT_RW'(dvs_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      src_in  = src_ff;
      res_in  = res_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         dvs_in  = divisor;
         res_in  = '0;
         if (cmd.is_div) begin
            rem_in = ROOT_RW'(dividend >> QW);
            src_in = 64'(dividend) << (64 - QW);
            cnt_in = CW'(QW);
         end else begin
            rem_in = '0;
            src_in = radicand;
            cnt_in = CW'(ROOT_STEPS);
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            if (t_div >= dvs_ext) begin
               rem_in = t_div - dvs_ext;
               res_in = {res_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = t_div;
               res_in = {res_ff[DW-2:0], 1'b0};
            end
            src_in = {src_ff[62:0], 1'b0};
         end else begin
            if (t_root >= trial) begin
               rem_in = t_root - trial;
               res_in = {res_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = t_root;
               res_in = {res_ff[DW-2:0], 1'b0};
            end
            src_in = {src_ff[61:0], 2'b00};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      src_ff <= src_in;
      res_ff <= res_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule
`default_nettype wire

### src/gizmo_axis_ray_pick.sv
// gizmo axis ray pick: sequencer and datapath around a shared multiplier
// locked beat: goes from accept straight to S_DONE, with no arithmetic
// unlocked beat: runs the 32-step root, three FRAC_BITS+1 step divides
// and the multiply sequence
// throughput: one beat at a time, next beat accepted once the result is registered
// reset: synchronous, clears the held axis, sets tolerance to 66, no beat pending
`timescale 1ns / 1ps
`default_nettype none
module gizmo_axis_ray_pick import garp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [TOL_W-1:0] csr_wdata
);

   localparam int DFW = DW + 1;
   localparam int UW  = FRAC_BITS + 2;
   localparam int QW  = FRAC_BITS + 1;
   localparam int WW  = DFW + UW + 1 - FRAC_BITS;
   localparam int SW  = DFW + UW + 2 - FRAC_BITS;
   localparam int UQW = 2 * FRAC_BITS + 1;
   localparam int N2W = 2 * FRAC_BITS + 2;
   localparam int CLW = N2W - FRAC_BITS;
   localparam int NW  = DW + FRAC_BITS + 1;
   localparam int ACW = MUL_PW;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MUL    = 9'b000000010,
      S_ACC    = 9'b000000100,
      S_ROOTGO = 9'b000001000,
      S_ROOT   = 9'b000010000,
      S_DIVGO  = 9'b000100000,
      S_DIV    = 9'b001000000,
      S_AXIS   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   typedef enum logic [4:0] {
      OP_DXX, OP_DYY, OP_DZZ,
      OP_C0A, OP_C0B, OP_C1A, OP_C1B, OP_C2A, OP_C2B,
      OP_S0, OP_S1, OP_S2,
      OP_U0, OP_U1, OP_U2,
      OP_W0, OP_W1, OP_W2,
      OP_NUM, OP_GAP
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [1:0] ax_ff, ax_in;
   logic [1:0] dv_ff, dv_in;

   logic signed [DW-1:0]  dir_ff [3];
   logic signed [DW-1:0]  dir_in [3];
   logic signed [DFW-1:0] diff_ff [3];
   logic signed [DFW-1:0] diff_in [3];
   logic signed [UW-1:0]  u_ff [3];
   logic signed [UW-1:0]  u_in [3];
   logic signed [WW-1:0]  w_ff [3];
   logic signed [WW-1:0]  w_in [3];
   logic [UQW-1:0]        usq_ff [3];
   logic [UQW-1:0]        usq_in [3];
   logic [61:0]           wsq_ff [3];
   logic [61:0]           wsq_in [3];
   logic [2:0]            big_ff, big_in;
   logic signed [SW-1:0]  s_ff, s_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic [63:0]           wsum_ff, wsum_in;
   logic [DW-1:0]         len_ff, len_in;
   logic [TOL_W-1:0]      tol_ff, tol_in;
   logic [1:0]            held_ff, held_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [MUL_PW-1:0] prod;

   unit_cmd_type     ucmd;
   unit_stat_type    ustat;
   logic [DW-1:0]    ures;
   logic [NW-1:0]    udividend;
   logic [DW-1:0]    dmag;

   logic [1:0]            bi, ci;
   logic [N2W-1:0]        n2;
   logic [CLW-1:0]        cl2;
   logic                  par, par_hit;
   logic signed [ACW-1:0] num;
   logic signed [UW-1:0]  qs;
   logic                  req_fire;

   function automatic logic w_big(input logic signed [WW-1:0] w);
      logic fits;
      fits = (w[WW-1:31] == '0) || ((&w[WW-1:31]) && (|w[30:0]));
      return !fits;
   endfunction

   garp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   garp_root_div #(.FRAC_BITS(FRAC_BITS)) u_root_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ucmd),
      .radicand (acc_ff[63:0]),
      .dividend (udividend),
      .divisor  (len_ff),
      .stat     (ustat),
      .result   (ures)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dmag      = dir_ff[dv_ff][DW-1] ? DW'(-dir_ff[dv_ff]) : DW'(dir_ff[dv_ff]);
   assign udividend = (NW'(dmag) << FRAC_BITS) + NW'(len_ff >> 1);
   assign qs        = UW'(ures[QW-1:0]);

   always_comb begin
      unique case (ax_ff)
         2'd0: begin
            bi = 2'd1;
            ci = 2'd2;
         end
         2'd1: begin
            bi = 2'd2;
            ci = 2'd0;
         end
         default: begin
            bi = 2'd0;
            ci = 2'd1;
         end
      endcase
   end

   assign n2      = N2W'(usq_ff[bi]) + N2W'(usq_ff[ci]);
   assign cl2     = n2[N2W-1:FRAC_BITS];
   assign par     = (n2 == '0) || (32'(cl2) < 32'(tol_ff));
   assign par_hit = (big_ff == 3'b000) && ((wsum_ff >> FRAC_BITS) < 64'(tol_ff));
   assign num     = prod - (ACW'(diff_ff[ax_ff]) <<< FRAC_BITS);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op_ff)
         OP_DXX: begin mul_a = MUL_AW'(dir_ff[0]);  mul_b = MUL_BW'(dir_ff[0]); end
         OP_DYY: begin mul_a = MUL_AW'(dir_ff[1]);  mul_b = MUL_BW'(dir_ff[1]); end
         OP_DZZ: begin mul_a = MUL_AW'(dir_ff[2]);  mul_b = MUL_BW'(dir_ff[2]); end
         OP_C0A: begin mul_a = MUL_AW'(diff_ff[1]); mul_b = MUL_BW'(u_ff[2]); end
         OP_C0B: begin mul_a = MUL_AW'(diff_ff[2]); mul_b = MUL_BW'(u_ff[1]); end
         OP_C1A: begin mul_a = MUL_AW'(diff_ff[2]); mul_b = MUL_BW'(u_ff[0]); end
         OP_C1B: begin mul_a = MUL_AW'(diff_ff[0]); mul_b = MUL_BW'(u_ff[2]); end
         OP_C2A: begin mul_a = MUL_AW'(diff_ff[0]); mul_b = MUL_BW'(u_ff[1]); end
         OP_C2B: begin mul_a = MUL_AW'(diff_ff[1]); mul_b = MUL_BW'(u_ff[0]); end
         OP_S0:  begin mul_a = MUL_AW'(diff_ff[0]); mul_b = MUL_BW'(u_ff[0]); end
         OP_S1:  begin mul_a = MUL_AW'(diff_ff[1]); mul_b = MUL_BW'(u_ff[1]); end
         OP_S2:  begin mul_a = MUL_AW'(diff_ff[2]); mul_b = MUL_BW'(u_ff[2]); end
         OP_U0:  begin mul_a = MUL_AW'(u_ff[0]);    mul_b = MUL_BW'(u_ff[0]); end
         OP_U1:  begin mul_a = MUL_AW'(u_ff[1]);    mul_b = MUL_BW'(u_ff[1]); end
         OP_U2:  begin mul_a = MUL_AW'(u_ff[2]);    mul_b = MUL_BW'(u_ff[2]); end
         OP_W0:  begin mul_a = MUL_AW'(w_ff[0]);    mul_b = $signed(w_ff[0][31:0]); end
         OP_W1:  begin mul_a = MUL_AW'(w_ff[1]);    mul_b = $signed(w_ff[1][31:0]); end
         OP_W2:  begin mul_a = MUL_AW'(w_ff[2]);    mul_b = $signed(w_ff[2][31:0]); end
         OP_NUM: begin mul_a = MUL_AW'(s_ff);       mul_b = MUL_BW'(u_ff[ax_ff]); end
         OP_GAP: begin
            mul_a = $signed(MUL_AW'(tol_ff));
            mul_b = $signed(MUL_BW'(cl2));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ax_in        = ax_ff;
      dv_in        = dv_ff;
      dir_in       = dir_ff;
      diff_in      = diff_ff;
      u_in         = u_ff;
      w_in         = w_ff;
      usq_in       = usq_ff;
      wsq_in       = wsq_ff;
      big_in       = big_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      wsum_in      = wsum_ff;
      len_in       = len_ff;
      held_in      = held_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ucmd         = '0;
      tol_in       = csr_we ? csr_wdata : tol_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               dir_in[0]  = req_data.ray_dir_x;
               dir_in[1]  = req_data.ray_dir_y;
               dir_in[2]  = req_data.ray_dir_z;
               diff_in[0] = DFW'(req_data.object_x) - DFW'(req_data.ray_origin_x);
               diff_in[1] = DFW'(req_data.object_y) - DFW'(req_data.ray_origin_y);
               diff_in[2] = DFW'(req_data.object_z) - DFW'(req_data.ray_origin_z);
               hit_in     = 1'b0;
               if (req_data.axis_locked) begin
                  state_in = S_DONE;
               end else begin
                  held_in  = AXIS_NONE;
                  op_in    = OP_DXX;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            op_in    = op_type'(op_ff + 5'd1);
            state_in = S_MUL;
            unique case (op_ff)
               OP_DXX, OP_C0A, OP_C1A, OP_C2A, OP_S0: acc_in = prod;
               OP_DYY, OP_S1: acc_in = acc_ff + prod;
               OP_DZZ: begin
                  acc_in   = acc_ff + prod;
                  state_in = S_ROOTGO;
               end
               OP_C0B: w_in[0] = WW'((acc_ff - prod) >>> FRAC_BITS);
               OP_C1B: w_in[1] = WW'((acc_ff - prod) >>> FRAC_BITS);
               OP_C2B: w_in[2] = WW'((acc_ff - prod) >>> FRAC_BITS);
               OP_S2:  s_in = SW'((acc_ff + prod) >>> FRAC_BITS);
               OP_U0:  usq_in[0] = prod[UQW-1:0];
               OP_U1:  usq_in[1] = prod[UQW-1:0];
               OP_U2:  usq_in[2] = prod[UQW-1:0];
               OP_W0: begin
                  wsq_in[0] = prod[61:0];
                  big_in[0] = w_big(w_ff[0]);
                  wsum_in   = prod[63:0];
               end
               OP_W1: begin
                  wsq_in[1] = prod[61:0];
                  big_in[1] = w_big(w_ff[1]);
                  wsum_in   = wsum_ff + prod[63:0];
               end
               OP_W2: begin
                  wsq_in[2] = prod[61:0];
                  big_in[2] = w_big(w_ff[2]);
                  wsum_in   = wsum_ff + prod[63:0];
                  ax_in     = 2'd0;
                  state_in  = S_AXIS;
               end
               OP_NUM: begin
                  if (!num[ACW-1] && ($unsigned(num) <= ACW'(n2))) begin
                     op_in = OP_GAP;
                  end else if (ax_ff == 2'd2) begin
                     state_in = S_DONE;
                  end else begin
                     ax_in    = ax_ff + 2'd1;
                     state_in = S_AXIS;
                  end
               end
               OP_GAP: begin
                  if (!big_ff[ax_ff] && (ACW'(wsq_ff[ax_ff]) < $unsigned(prod))) begin
                     held_in  = ax_ff + 2'd1;
                     hit_in   = 1'b1;
                     state_in = S_DONE;
                  end else if (ax_ff == 2'd2) begin
                     state_in = S_DONE;
                  end else begin
                     ax_in    = ax_ff + 2'd1;
                     state_in = S_AXIS;
                  end
               end
               default: state_in = S_MUL;
            endcase
         end
         S_ROOTGO: begin
            ucmd.start  = 1'b1;
            ucmd.is_div = 1'b0;
            state_in    = S_ROOT;
         end
         S_ROOT: begin
            if (ustat.done) begin
               len_in = ures;
               if (ures == '0) begin
                  state_in = S_DONE;
               end else begin
                  dv_in    = 2'd0;
                  state_in = S_DIVGO;
               end
            end
         end
         S_DIVGO: begin
            ucmd.start  = 1'b1;
            ucmd.is_div = 1'b1;
            state_in    = S_DIV;
         end
         S_DIV: begin
            if (ustat.done) begin
               u_in[dv_ff] = dir_ff[dv_ff][DW-1] ? -qs : qs;
               if (dv_ff == 2'd2) begin
                  op_in    = OP_C0A;
                  state_in = S_MUL;
               end else begin
                  dv_in    = dv_ff + 2'd1;
                  state_in = S_DIVGO;
               end
            end
         end
         S_AXIS: begin
            if (!par) begin
               op_in    = OP_NUM;
               state_in = S_MUL;
            end else if (par_hit) begin
               held_in  = ax_ff + 2'd1;
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else if (ax_ff == 2'd2) begin
               state_in = S_DONE;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.hit          = hit_ff;
               rsp_data_in.picked_axis  = held_ff;
               state_in                 = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= AXIS_NONE;
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ax_ff       <= ax_in;
      dv_ff       <= dv_in;
      dir_ff      <= dir_in;
      diff_ff     <= diff_in;
      u_ff        <= u_in;
      w_ff        <= w_in;
      usq_ff      <= usq_in;
      wsq_ff      <= wsq_in;
      big_ff      <= big_in;
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      wsum_ff     <= wsum_in;
      len_ff      <= len_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready stayed high after an accepted beat");

   a_unit_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      ustat.done |-> (state_ff == S_ROOT || state_ff == S_DIV))
      else $error("root/div unit finished outside a wait state");

   a_locked_keeps_axis: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.axis_locked) |=> $stable(held_ff))
      else $error("held axis changed on a locked beat");
`endif

endmodule
`default_nettype wire
